### rtl/ccef_pkg.sv
// ============================================================================
// ccef_pkg - shared types and constants for the control-chord event filter
// Field widths, register indexes, key value codes and the command and status
// words that pass between the controller and the datapath.
// ============================================================================
package ccef_pkg;

    // Field widths
    localparam int TYPE_W     = 5;
    localparam int CODE_W     = 10;
    localparam int VALUE_W    = 32;
    localparam int ENTRY_W    = TYPE_W + CODE_W + VALUE_W;
    localparam int HELD_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Default buffer depth
    localparam int CCEF_DEPTH_DEF = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_TYPE   = 2'd0,
        CFG_LEFT_CTRL  = 2'd1,
        CFG_RIGHT_CTRL = 2'd2,
        CFG_C_KEY      = 2'd3
    } ccef_cfg_idx_t;

    // Configuration reset values
    localparam logic [TYPE_W-1:0] KEY_TYPE_RST   = TYPE_W'(1);
    localparam logic [CODE_W-1:0] LEFT_CTRL_RST  = CODE_W'(29);
    localparam logic [CODE_W-1:0] RIGHT_CTRL_RST = CODE_W'(97);
    localparam logic [CODE_W-1:0] C_KEY_RST      = CODE_W'(46);

    // Key event values
    localparam logic [VALUE_W-1:0] KEY_RELEASE = VALUE_W'(0);
    localparam logic [VALUE_W-1:0] KEY_PRESS   = VALUE_W'(1);
    localparam logic [VALUE_W-1:0] KEY_REPEAT  = VALUE_W'(2);

    // Controller to datapath
    typedef struct packed {
        logic capture;      // latch the accepted word
        logic decide;       // classify the word, buffer it, update run state
        logic rd_first;     // fetch the first pending entry
        logic drain_load;   // move fetched entry to the output, fetch next
        logic emit_load;    // move the held word to the output
    } ccef_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic drain;        // decision: buffered run is released
        logic pass;         // decision: word passes straight through
        logic pass_q;       // pass decision, held for the rest of the item
        logic out_free;     // output register can take a word
        logic drain_end;    // fetched entry is the last of the run
    } ccef_sts_t;

endpackage

### rtl/ccef_ram.sv
// ============================================================================
// ccef_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module ccef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ccef_ctrl.sv
// ============================================================================
// ccef_ctrl - sequencing controller for the control-chord event filter
// Takes one word at a time, has the datapath classify it, then drains the
// pending run and/or emits the word itself.
// ============================================================================
module ccef_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ccef_pkg::ccef_sts_t sts,
    output ccef_pkg::ccef_ctl_t ctl
);
    import ccef_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_PREP   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                ctl.decide = 1'b1;
                if (sts.drain)
                begin
                    state_next = ST_PREP;
                end
                else if (sts.pass)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP:
            begin
                ctl.rd_first = 1'b1;
                state_next   = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (sts.out_free)
                begin
                    ctl.drain_load = 1'b1;
                    if (sts.drain_end)
                    begin
                        state_next = sts.pass_q ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/ccef_dpath.sv
// ============================================================================
// ccef_dpath - datapath of the control-chord event filter
// Configuration registers, latched input word, held-key count, pending RAM
// with its fill count, run flags and the output register.
// ============================================================================
module ccef_dpath #(
    parameter int DEPTH = ccef_pkg::CCEF_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    input  logic [ccef_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccef_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input word
    input  logic                                cmd,
    input  logic [ccef_pkg::TYPE_W-1:0]         ev_type,
    input  logic [ccef_pkg::CODE_W-1:0]         ev_code,
    input  logic signed [ccef_pkg::VALUE_W-1:0] ev_value,
    // output word
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ccef_pkg::TYPE_W-1:0]         out_type,
    output logic [ccef_pkg::CODE_W-1:0]         out_code,
    output logic signed [ccef_pkg::VALUE_W-1:0] out_value,
    output logic                                last_of_run,
    output logic                                lost_some,
    // controller
    input  ccef_pkg::ccef_ctl_t                 ctl,
    output ccef_pkg::ccef_sts_t                 sts
);
    import ccef_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Configuration registers
    logic [TYPE_W-1:0]  key_type_reg;
    logic [CODE_W-1:0]  left_ctrl_reg;
    logic [CODE_W-1:0]  right_ctrl_reg;
    logic [CODE_W-1:0]  c_key_reg;

    // Latched word
    logic               item_cmd_reg;
    logic [TYPE_W-1:0]  item_type_reg;
    logic [CODE_W-1:0]  item_code_reg;
    logic [VALUE_W-1:0] item_value_reg;

    // Run state
    logic [HELD_W-1:0]  held_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic               saw_reg;
    logic               ovf_reg;
    logic               pass_reg;

    // Output register
    logic               out_valid_reg;
    logic [TYPE_W-1:0]  out_type_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               out_lost_reg;

    // Decision terms
    logic               is_key;
    logic               is_ctrl;
    logic               val_press;
    logic               val_repeat;
    logic               val_release;
    logic [HELD_W-1:0]  held_inc;
    logic [HELD_W-1:0]  held_fin;
    logic [HELD_W-1:0]  held_upd;
    logic               push;
    logic               settle;
    logic               pass;
    logic               chord_set;
    logic               room;
    logic [CW-1:0]      count_push;
    logic               drain;
    logic               drop_now;
    logic [CW-1:0]      idx_inc;
    logic               drain_end;
    logic               out_free;

    // RAM ports
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_type_reg   <= KEY_TYPE_RST;
            left_ctrl_reg  <= LEFT_CTRL_RST;
            right_ctrl_reg <= RIGHT_CTRL_RST;
            c_key_reg      <= C_KEY_RST;
        end
        else if (cfg_valid)
        begin
            unique case (ccef_cfg_idx_t'(cfg_index))
                CFG_KEY_TYPE:   key_type_reg   <= cfg_data[TYPE_W-1:0];
                CFG_LEFT_CTRL:  left_ctrl_reg  <= cfg_data[CODE_W-1:0];
                CFG_RIGHT_CTRL: right_ctrl_reg <= cfg_data[CODE_W-1:0];
                CFG_C_KEY:      c_key_reg      <= cfg_data[CODE_W-1:0];
                default:        key_type_reg   <= key_type_reg;
            endcase
        end
    end

    // Word latch
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_cmd_reg   <= cmd;
            item_type_reg  <= ev_type;
            item_code_reg  <= ev_code;
            item_value_reg <= ev_value;
        end
    end

    // Key classification
    assign is_key      = (item_type_reg == key_type_reg);
    assign is_ctrl     = is_key && ((item_code_reg == left_ctrl_reg) ||
                                    (item_code_reg == right_ctrl_reg));
    assign val_press   = (item_value_reg == KEY_PRESS);
    assign val_repeat  = (item_value_reg == KEY_REPEAT);
    assign val_release = (item_value_reg == KEY_RELEASE);

    // Held count: saturating press, release never below zero
    assign held_inc = (val_press && (held_reg != '1)) ? held_reg + HELD_W'(1) : held_reg;
    assign held_fin = (val_release && (held_inc != '0)) ? held_inc - HELD_W'(1) : held_inc;

    // What the word does
    always_comb
    begin
        push      = 1'b0;
        settle    = 1'b0;
        pass      = 1'b0;
        chord_set = 1'b0;
        held_upd  = held_reg;
        if (item_cmd_reg)
        begin
            settle = (held_reg == '0);
        end
        else if (is_ctrl)
        begin
            push     = 1'b1;
            held_upd = held_fin;
            settle   = val_release && (held_fin == '0);
        end
        else if (held_reg != '0)
        begin
            push      = 1'b1;
            chord_set = is_key && (item_code_reg == c_key_reg) && (val_press || val_repeat);
        end
        else
        begin
            pass   = 1'b1;
            settle = (count_reg != '0) || ovf_reg;
        end
    end

    assign room       = (count_reg < FULL_CNT);
    assign count_push = (push && room) ? count_reg + CW'(1) : count_reg;
    assign drain      = settle && !saw_reg && (count_push != '0);
    assign drop_now   = settle && !drain;

    assign idx_inc    = idx_reg + CW'(1);
    assign drain_end  = (idx_inc == count_reg);
    assign out_free   = !out_valid_reg || out_ready;

    // Run state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            count_reg <= '0;
            saw_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else if (ctl.decide)
        begin
            held_reg <= held_upd;
            pass_reg <= pass;
            if (drop_now)
            begin
                count_reg <= '0;
                saw_reg   <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_push;
                saw_reg   <= saw_reg | chord_set;
                ovf_reg   <= ovf_reg | (push && !room);
            end
        end
        else if (ctl.drain_load && drain_end)
        begin
            count_reg <= '0;
            saw_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
    end

    // Drain index: entry currently in the RAM read register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (ctl.rd_first)
        begin
            idx_reg <= '0;
        end
        else if (ctl.drain_load)
        begin
            idx_reg <= idx_inc;
        end
    end

    // Pending store
    assign ram_we    = ctl.decide && push && room;
    assign ram_re    = ctl.rd_first || ctl.drain_load;
    assign ram_raddr = ctl.rd_first ? '0 : idx_inc[AW-1:0];

    ccef_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pending (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({item_type_reg, item_code_reg, item_value_reg}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.drain_load || ctl.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (ctl.drain_load)
        begin
            out_type_reg  <= ram_rdata[ENTRY_W-1 -: TYPE_W];
            out_code_reg  <= ram_rdata[VALUE_W +: CODE_W];
            out_value_reg <= ram_rdata[VALUE_W-1:0];
            out_last_reg  <= drain_end && !pass_reg;
            out_lost_reg  <= ovf_reg;
        end
        else if (ctl.emit_load)
        begin
            out_type_reg  <= item_type_reg;
            out_code_reg  <= item_code_reg;
            out_value_reg <= item_value_reg;
            out_last_reg  <= 1'b1;
            out_lost_reg  <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_type    = out_type_reg;
    assign out_code    = out_code_reg;
    assign out_value   = signed'(out_value_reg);
    assign last_of_run = out_last_reg;
    assign lost_some   = out_lost_reg;

    assign sts.drain     = drain;
    assign sts.pass      = pass;
    assign sts.pass_q    = pass_reg;
    assign sts.out_free  = out_free;
    assign sts.drain_end = drain_end;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("pending count beyond buffer depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(ctl.drain_load || ctl.emit_load))
        else $error("waiting output word overwritten");

    a_no_chord_release: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.drain_load |-> !saw_reg)
        else $error("run released although chord was seen");

    a_fetch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_first |-> (count_reg != '0))
        else $error("drain started on an empty buffer");

endmodule

### rtl/ctrl_chord_event_filter_core.sv
// ============================================================================
// ctrl_chord_event_filter_core - control-chord event filter, top level
// Buffers events around control-key holds and releases or drops the run.
// ============================================================================
// Path: a straight-through word with nothing pending goes via the word latch,
//   the decide and the emit state to the output; a released run is fetched from
//   the RAM, then drains one word a cycle while the output is free. A new word is
//   taken only once the last is through; the output handshake paces the drain.
// Reset: rst_n clears control state and restores register defaults at once;
//   the pending RAM is not cleared and only entries below its fill count go out.
module ctrl_chord_event_filter_core #(
    parameter int DEPTH = ccef_pkg::CCEF_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ccef_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccef_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [ccef_pkg::TYPE_W-1:0]         ev_type,
    input  logic [ccef_pkg::CODE_W-1:0]         ev_code,
    input  logic signed [ccef_pkg::VALUE_W-1:0] ev_value,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ccef_pkg::TYPE_W-1:0]         out_type,
    output logic [ccef_pkg::CODE_W-1:0]         out_code,
    output logic signed [ccef_pkg::VALUE_W-1:0] out_value,
    output logic                                last_of_run,
    output logic                                lost_some
);
    import ccef_pkg::*;

    ccef_ctl_t ctl;
    ccef_sts_t sts;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    ccef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    ccef_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .ev_type     (ev_type),
        .ev_code     (ev_code),
        .ev_value    (ev_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_type    (out_type),
        .out_code    (out_code),
        .out_value   (out_value),
        .last_of_run (last_of_run),
        .lost_some   (lost_some),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule

### verif/tb_ctrl_chord_event_filter_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_ctrl_chord_event_filter_core - self-checking bench for the chord filter
// Drives events and flush commands through the input channel and predicts
// every released, dropped and passed word. Each emitted word is checked
// field by field. The run covers four register settings, overflow of the
// pending buffer and a deep hold of several control keys. Both channels
// idle and stall at random.
// ============================================================================
module tb_ctrl_chord_event_filter_core;
    import ccef_pkg::*;

    typedef enum logic {
        CMD_EVENT = 1'b0,
        CMD_FLUSH = 1'b1
    } ev_cmd_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  etype;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } key_event_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  etype;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               lost;
    } emitted_t;

    // Tracks the filter state and the queue of words still due at the output
    class chord_filter_scoreboard;
        logic [TYPE_W-1:0] key_type  = KEY_TYPE_RST;
        logic [CODE_W-1:0] lctrl     = LEFT_CTRL_RST;
        logic [CODE_W-1:0] rctrl     = RIGHT_CTRL_RST;
        logic [CODE_W-1:0] ckey      = C_KEY_RST;

        key_event_t  held_run [CCEF_DEPTH_DEF];
        int unsigned run_len    = 0;
        int unsigned held_ctrl  = 0;
        bit          chord_seen = 1'b0;
        bit          run_lost   = 1'b0;

        emitted_t    due_q [$];

        int unsigned errors        = 0;
        int unsigned accepted      = 0;
        int unsigned checked       = 0;
        int unsigned runs_released = 0;
        int unsigned runs_lossy    = 0;
        int unsigned runs_dropped  = 0;
        int unsigned peak_held     = 0;

        function void set_reg(ccef_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_KEY_TYPE:   key_type = data[TYPE_W-1:0];
                CFG_LEFT_CTRL:  lctrl    = data;
                CFG_RIGHT_CTRL: rctrl    = data;
                CFG_C_KEY:      ckey     = data;
                default:        ;
            endcase
        endfunction

        function int unsigned outstanding();
            return due_q.size();
        endfunction

        // Append a word to the tail of the due queue
        function void add_due(emitted_t w);
            due_q.insert(due_q.size(), w);
        endfunction

        function void push_pending(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                                   logic [VALUE_W-1:0] v);
            if (run_len < CCEF_DEPTH_DEF)
            begin
                held_run[run_len] = '{t, c, v};
                run_len++;
            end
            else
                run_lost = 1'b1;
        endfunction

        // Release the pending run in order, or drop it when the chord was seen
        function void settle_run();
            if (!chord_seen)
            begin
                for (int unsigned i = 0; i < run_len; i++)
                    add_due('{held_run[i].etype, held_run[i].code,
                              held_run[i].value, 1'b0, run_lost});
                if (run_len > 0)
                    runs_released++;
                if (run_lost)
                    runs_lossy++;
            end
            else
                runs_dropped++;
            chord_seen = 1'b0;
            run_lost   = 1'b0;
            run_len    = 0;
        endfunction

        // Accepted input word: work out what it releases
        function void note_word(ev_cmd_t op, logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                                logic [VALUE_W-1:0] v);
            int unsigned first;
            bit          is_key;
            first  = due_q.size();
            is_key = (t == key_type);
            accepted++;
            if (op == CMD_FLUSH)
            begin
                if (held_ctrl == 0)
                    settle_run();
            end
            else if (is_key && (c == lctrl || c == rctrl))
            begin
                if (v == KEY_PRESS && held_ctrl < 255)
                    held_ctrl++;
                push_pending(t, c, v);
                if (v == KEY_RELEASE && held_ctrl > 0)
                    held_ctrl--;
                if (v == KEY_RELEASE && held_ctrl == 0)
                    settle_run();
            end
            else if (held_ctrl > 0)
            begin
                push_pending(t, c, v);
                if (is_key && c == ckey && (v == KEY_PRESS || v == KEY_REPEAT))
                    chord_seen = 1'b1;
            end
            else
            begin
                // straight through, after whatever is still pending
                if (run_len > 0 || run_lost)
                    settle_run();
                add_due('{t, c, v, 1'b0, 1'b0});
            end
            if (due_q.size() > first)
                due_q[due_q.size()-1].last = 1'b1;
            if (held_ctrl > peak_held)
                peak_held = held_ctrl;
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] exp_v,
                                    logic [VALUE_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Output word: compare with the oldest word due
        function void check_word(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                                 logic [VALUE_W-1:0] v, logic last, logic lost);
            emitted_t exp_w;
            if (due_q.size() == 0)
            begin
                $error("unexpected word: type 'h%0h code 'h%0h value 'h%0h", t, c, v);
                errors++;
                return;
            end
            exp_w = due_q.pop_front();
            checked++;
            compare_field("out_type", VALUE_W'(exp_w.etype), VALUE_W'(t));
            compare_field("out_code", VALUE_W'(exp_w.code), VALUE_W'(c));
            compare_field("out_value", exp_w.value, v);
            compare_field("last_of_run", VALUE_W'(exp_w.last), VALUE_W'(last));
            compare_field("lost_some", VALUE_W'(exp_w.lost), VALUE_W'(lost));
        endfunction
    endclass

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = CCEF_DEPTH_DEF + 8;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic                     cmd       = 1'b0;
    logic [TYPE_W-1:0]        ev_type   = '0;
    logic [CODE_W-1:0]        ev_code   = '0;
    logic signed [VALUE_W-1:0] ev_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [TYPE_W-1:0]        out_type;
    logic [CODE_W-1:0]        out_code;
    logic signed [VALUE_W-1:0] out_value;
    logic                     last_of_run;
    logic                     lost_some;

    chord_filter_scoreboard filter_sb;
    int          burst_left  = 0;
    int          cycle_count = 0;
    logic [7:0]  stall_phase = '0;

    ctrl_chord_event_filter_core #(
        .DEPTH(CCEF_DEPTH_DEF)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .ev_type    (ev_type),
        .ev_code    (ev_code),
        .ev_value   (ev_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_type   (out_type),
        .out_code   (out_code),
        .out_value  (out_value),
        .last_of_run(last_of_run),
        .lost_some  (lost_some)
    );

    always #1 clk = ~clk;

    // Output side: check accepted words, then set the stall pattern
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
            filter_sb.check_word(out_type, out_code, out_value, last_of_run, lost_some);
        stall_phase <= stall_phase + 8'd1;
        case (stall_phase[7:6])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= (stall_phase[1:0] == 2'd3);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ctrl_chord_event_filter_core verification failed");
        $finish;
    end

    // Send one word; bursts of random length with random gaps between
    task automatic send_word(ev_cmd_t op, logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                             logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= op;
        ev_type  <= t;
        ev_code  <= c;
        ev_value <= v;
        do @(posedge clk); while (!in_ready);
        filter_sb.note_word(op, t, c, v);
    endtask

    // Hold off until every due word has come out and the block is idle
    task automatic drain_all();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (filter_sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(ccef_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        filter_sb.set_reg(idx, data);
    endtask

    task automatic load_regs(logic [TYPE_W-1:0] kt, logic [CODE_W-1:0] lc,
                             logic [CODE_W-1:0] rc, logic [CODE_W-1:0] ck);
        write_reg(CFG_KEY_TYPE, CFG_DATA_W'(kt));
        write_reg(CFG_LEFT_CTRL, lc);
        write_reg(CFG_RIGHT_CTRL, rc);
        write_reg(CFG_C_KEY, ck);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CODE_W-1:0] pick_ctrl();
        return $urandom_range(0, 1) ? filter_sb.lctrl : filter_sb.rctrl;
    endfunction

    function automatic logic [VALUE_W-1:0] key_value();
        case ($urandom_range(0, 3))
            0:       return KEY_RELEASE;
            1:       return KEY_PRESS;
            2:       return KEY_REPEAT;
            default: return $urandom();
        endcase
    endfunction

    // Let go of every held control key, then flush what is left
    task automatic release_ctrl();
        while (filter_sb.held_ctrl > 0)
            send_word(CMD_EVENT, filter_sb.key_type, filter_sb.lctrl, KEY_RELEASE);
        send_word(CMD_FLUSH, TYPE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 767)),
                  $urandom());
    endtask

    // One control hold with random content, usually closed again
    task automatic chord_sequence();
        int presses;
        int inner;
        int roll;
        send_word(CMD_EVENT, filter_sb.key_type, pick_ctrl(), KEY_PRESS);
        presses = 1;
        inner = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
        repeat (inner)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
                send_word(CMD_EVENT, filter_sb.key_type, filter_sb.ckey,
                          $urandom_range(0, 1) ? KEY_PRESS : KEY_REPEAT);
            else if (roll < 22)
            begin
                send_word(CMD_EVENT, filter_sb.key_type, pick_ctrl(), KEY_PRESS);
                presses++;
            end
            else if (roll < 27)
                send_word(CMD_EVENT, filter_sb.key_type, pick_ctrl(),
                          $urandom_range(0, 1) ? KEY_REPEAT : ($urandom() | 32'h8000_0000));
            else if (roll < 32)
                send_word(CMD_FLUSH, TYPE_W'($urandom_range(0, 31)),
                          CODE_W'($urandom_range(0, 767)), $urandom());
            else if (roll < 45)
                send_word(CMD_EVENT, TYPE_W'($urandom_range(0, 31)),
                          CODE_W'($urandom_range(0, 767)), $urandom());
            else
                send_word(CMD_EVENT, filter_sb.key_type, CODE_W'($urandom_range(0, 767)),
                          key_value());
        end
        if ($urandom_range(0, 9) != 0)
            repeat (presses)
                send_word(CMD_EVENT, filter_sb.key_type, pick_ctrl(), KEY_RELEASE);
    endtask

    task automatic random_phase(int unsigned n_words);
        int unsigned start;
        int          roll;
        start = filter_sb.accepted;
        while (filter_sb.accepted - start < n_words)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                chord_sequence();
            else if (roll < 78)
                send_word(CMD_EVENT, $urandom_range(0, 1) ? filter_sb.key_type
                                                          : TYPE_W'($urandom_range(0, 31)),
                          CODE_W'($urandom_range(0, 767)), $urandom());
            else if (roll < 88)
                send_word(CMD_FLUSH, TYPE_W'($urandom_range(0, 31)),
                          CODE_W'($urandom_range(0, 767)), $urandom());
            else if (roll < 97)
                // stray control word: lone release or an odd value
                send_word(CMD_EVENT, filter_sb.key_type, pick_ctrl(),
                          $urandom_range(0, 1) ? KEY_RELEASE : $urandom());
            else
                drain_all();
            if (filter_sb.held_ctrl > 2)
                release_ctrl();
        end
        release_ctrl();
        drain_all();
    endtask

    // Reset register values; each special case in turn
    task automatic directed_cases();
        send_word(CMD_EVENT, 5'd0, 10'd0, 32'h8000_0000);
        send_word(CMD_EVENT, KEY_TYPE_RST, 10'd767, 32'h7fff_ffff);
        send_word(CMD_FLUSH, 5'd31, 10'd767, 32'hffff_ffff);
        // chord by press: run dropped
        send_word(CMD_EVENT, KEY_TYPE_RST, LEFT_CTRL_RST, KEY_PRESS);
        send_word(CMD_EVENT, 5'd31, 10'd5, 32'hffff_ffff);
        send_word(CMD_EVENT, KEY_TYPE_RST, C_KEY_RST, KEY_PRESS);
        send_word(CMD_FLUSH, 5'd0, 10'd0, 32'h0);
        send_word(CMD_EVENT, KEY_TYPE_RST, LEFT_CTRL_RST, KEY_RELEASE);
        // no chord: C code on another type, control repeat; run released
        send_word(CMD_EVENT, KEY_TYPE_RST, RIGHT_CTRL_RST, KEY_PRESS);
        send_word(CMD_EVENT, KEY_TYPE_RST, 10'd30, KEY_PRESS);
        send_word(CMD_EVENT, 5'd0, C_KEY_RST, KEY_PRESS);
        send_word(CMD_EVENT, KEY_TYPE_RST, RIGHT_CTRL_RST, KEY_REPEAT);
        send_word(CMD_EVENT, KEY_TYPE_RST, RIGHT_CTRL_RST, KEY_RELEASE);
        // release with nothing held
        send_word(CMD_EVENT, KEY_TYPE_RST, RIGHT_CTRL_RST, KEY_RELEASE);
        // odd control values stay pending until a flush or a pass
        send_word(CMD_EVENT, KEY_TYPE_RST, LEFT_CTRL_RST, 32'd5);
        send_word(CMD_FLUSH, 5'd0, 10'd0, 32'h0);
        send_word(CMD_EVENT, KEY_TYPE_RST, LEFT_CTRL_RST, 32'h8000_0000);
        send_word(CMD_EVENT, 5'd3, 10'd512, 32'd42);
        // chord by repeat across two control keys
        send_word(CMD_EVENT, KEY_TYPE_RST, LEFT_CTRL_RST, KEY_PRESS);
        send_word(CMD_EVENT, KEY_TYPE_RST, C_KEY_RST, KEY_REPEAT);
        send_word(CMD_EVENT, KEY_TYPE_RST, RIGHT_CTRL_RST, KEY_PRESS);
        send_word(CMD_EVENT, KEY_TYPE_RST, LEFT_CTRL_RST, KEY_RELEASE);
        send_word(CMD_EVENT, KEY_TYPE_RST, RIGHT_CTRL_RST, KEY_RELEASE);
        send_word(CMD_FLUSH, 5'd0, 10'd0, 32'h0);
        drain_all();
    endtask

    // Hold many control keys at once so the run overflows, then let go
    task automatic deep_hold();
        repeat (12)
            send_word(CMD_EVENT, filter_sb.key_type, pick_ctrl(), KEY_PRESS);
        while (filter_sb.held_ctrl > 0)
            send_word(CMD_EVENT, filter_sb.key_type, pick_ctrl(), KEY_RELEASE);
        drain_all();
    endtask

    initial
    begin
        filter_sb = new;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_cases();
        random_phase(60);

        load_regs(5'd31, 10'd767, 10'd0, 10'd512);
        random_phase(60);

        // both control codes the same, key type zero
        load_regs(5'd0, 10'd0, 10'd0, 10'd767);
        random_phase(60);

        load_regs(TYPE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 767)),
                  CODE_W'($urandom_range(0, 767)), CODE_W'($urandom_range(0, 767)));
        random_phase(60);

        load_regs(KEY_TYPE_RST, LEFT_CTRL_RST, RIGHT_CTRL_RST, C_KEY_RST);
        deep_hold();
        random_phase(60);

        $display("Run covered %0d input words and %0d output words over four register settings.",
                 filter_sb.accepted, filter_sb.checked);
        $display("Runs released %0d (%0d lossy), dropped on chord %0d, held count peak %0d.",
                 filter_sb.runs_released, filter_sb.runs_lossy, filter_sb.runs_dropped,
                 filter_sb.peak_held);
        if (filter_sb.errors == 0)
            $display("ctrl_chord_event_filter_core verification clean");
        else
            $display("ctrl_chord_event_filter_core verification failed");
        $finish;
    end

endmodule
